/* src/rtq_pkg.sv */
`default_nettype none
package rtq_pkg;

	localparam int DefaultSlots = 16;
	localparam int MaxResults = 16;

	localparam logic REQ_ADD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam logic [1:0] KIND_ADDED = 2'd0;
	localparam logic [1:0] KIND_FULL = 2'd1;
	localparam logic [1:0] KIND_FIRED = 2'd2;

	typedef struct packed {
		logic [31:0] expiry;
		logic [19:0] period;
		logic [15:0] limit;
		logic [15:0] fired;
		logic [7:0] tag;
		logic [15:0] age;
	} slot_word_t;

	typedef struct packed {
		logic capture;
		logic scan_start;
		logic scan_sel;
		logic add;
		logic fire;
		logic flush;
	} rtq_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic due_any;
		logic count_full;
	} rtq_status_t;

endpackage
`default_nettype wire

/* src/rtq_ram.sv */
`default_nettype none
module rtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* src/rtq_ctrl.sv */
`default_nettype none
module rtq_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic req_type,
	input wire rtq_pkg::rtq_status_t status,
	output rtq_pkg::rtq_cmd_t cmd,
	output logic busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_DUE,
		S_PICK,
		S_SEL,
		S_FIRE,
		S_FLUSH
	} state_t;

	state_t state_q;
	logic more;

	assign more = status.due_any && !status.count_full;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.capture = (state_q == S_IDLE) && start;
		cmd.scan_start = ((state_q == S_IDLE) && start && (req_type == rtq_pkg::REQ_TICK))
			|| ((state_q == S_PICK) && more);
		cmd.scan_sel = (state_q == S_PICK);
		cmd.add = (state_q == S_ADD);
		cmd.fire = (state_q == S_FIRE);
		cmd.flush = (state_q == S_FLUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (req_type == rtq_pkg::REQ_TICK) ? S_DUE : S_ADD;
					end
				end
				S_ADD: state_q <= S_IDLE;
				S_DUE: begin
					if (status.scan_done) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: state_q <= more ? S_SEL : S_FLUSH;
				S_SEL: begin
					if (status.scan_done) begin
						state_q <= S_FIRE;
					end
				end
				S_FIRE: state_q <= S_PICK;
				S_FLUSH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

/* src/rtq_dp.sv */
`default_nettype none
module rtq_dp #(
	parameter int TIMER_SLOTS = rtq_pkg::DefaultSlots
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire rtq_pkg::rtq_cmd_t cmd,
	output rtq_pkg::rtq_status_t status,
	input wire logic [7:0] timer_tag,
	input wire logic [19:0] delay,
	input wire logic [19:0] period,
	input wire logic [15:0] fire_limit,
	input wire logic req_type,
	output logic strobe,
	output logic [1:0] result_kind,
	output logic [7:0] tag_out,
	output logic [3:0] slot_index,
	output logic [31:0] fire_time,
	output logic last
);

	localparam int IW = $clog2(TIMER_SLOTS);
	localparam int XW = (IW > 4) ? IW : 4;
	localparam int WW = $bits(rtq_pkg::slot_word_t);
	localparam int CW = $clog2(rtq_pkg::MaxResults + 1);

	logic [31:0] time_q;
	logic [15:0] seq_q;
	logic [TIMER_SLOTS-1:0] valid_q;
	logic [TIMER_SLOTS-1:0] due_q;
	logic [7:0] tag_q;
	logic [19:0] delay_q;
	logic [19:0] period_q;
	logic [15:0] limit_q;

	logic run_q;
	logic sel_q;
	logic [IW-1:0] idx_q;
	logic vld_s1;
	logic [IW-1:0] vidx_s1;
	logic [CW-1:0] n_q;

	logic best_vld_q;
	logic [IW-1:0] best_idx_q;
	rtq_pkg::slot_word_t best_q;

	logic pend_vld_q;
	logic [7:0] pend_tag_q;
	logic [IW-1:0] pend_idx_q;
	logic [31:0] pend_time_q;

	rtq_pkg::slot_word_t rd_word;
	rtq_pkg::slot_word_t wr_word;
	logic [WW-1:0] rd_bits;
	logic we;
	logic [IW-1:0] waddr;

	logic free_any;
	logic [IW-1:0] free_idx;
	logic take;
	logic [15:0] age_new;
	logic [15:0] age_best;
	logic [15:0] fired_new;
	logic rearm;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign rd_word = rtq_pkg::slot_word_t'(rd_bits);
	assign age_new = seq_q - rd_word.age;
	assign age_best = seq_q - best_q.age;

	always_comb begin
		if (!best_vld_q) begin
			take = 1'b1;
		end else if (rd_word.expiry != best_q.expiry) begin
			take = rd_word.expiry < best_q.expiry;
		end else begin
			take = age_new > age_best;
		end
		take = take && due_q[vidx_s1];
	end

	assign fired_new = (best_q.fired == 16'hFFFF) ? best_q.fired : best_q.fired + 16'd1;
	assign rearm = (best_q.period != 20'd0)
		&& ((best_q.limit == 16'd0) || (fired_new < best_q.limit));

	always_comb begin
		wr_word = best_q;
		wr_word.expiry = time_q + 32'(best_q.period);
		wr_word.fired = fired_new;
		wr_word.age = seq_q;
		waddr = best_idx_q;
		we = cmd.fire && rearm;
		if (cmd.add) begin
			wr_word.expiry = time_q + 32'(delay_q);
			wr_word.period = period_q;
			wr_word.limit = limit_q;
			wr_word.fired = '0;
			wr_word.tag = tag_q;
			waddr = free_idx;
			we = free_any;
		end
	end

	rtq_ram #(.WIDTH(WW), .DEPTH(TIMER_SLOTS)) u_ram (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wr_word),
		.raddr(idx_q),
		.rdata(rd_bits)
	);

	assign status.scan_done = vld_s1 && (vidx_s1 == IW'(TIMER_SLOTS - 1));
	assign status.due_any = |due_q;
	assign status.count_full = (n_q == CW'(rtq_pkg::MaxResults));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			seq_q <= '0;
			valid_q <= '0;
			due_q <= '0;
			run_q <= 1'b0;
			sel_q <= 1'b0;
			idx_q <= '0;
			vld_s1 <= 1'b0;
			n_q <= '0;
			best_vld_q <= 1'b0;
			pend_vld_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.add || ((cmd.fire || cmd.flush) && pend_vld_q);
			vld_s1 <= run_q;
			if (cmd.capture) begin
				n_q <= '0;
				if (req_type == rtq_pkg::REQ_TICK) begin
					time_q <= time_q + 32'd1;
				end
			end
			if (cmd.scan_start) begin
				run_q <= 1'b1;
				sel_q <= cmd.scan_sel;
				idx_q <= '0;
				best_vld_q <= 1'b0;
			end else if (run_q) begin
				if (idx_q == IW'(TIMER_SLOTS - 1)) begin
					run_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (vld_s1) begin
				if (!sel_q) begin
					due_q[vidx_s1] <= valid_q[vidx_s1] && (rd_word.expiry < time_q);
				end else if (take) begin
					best_vld_q <= 1'b1;
				end
			end
			if (cmd.add) begin
				if (free_any) begin
					valid_q[free_idx] <= 1'b1;
					seq_q <= seq_q + 16'd1;
				end
			end
			if (cmd.fire) begin
				due_q[best_idx_q] <= 1'b0;
				n_q <= n_q + 1'b1;
				pend_vld_q <= 1'b1;
				if (rearm) begin
					seq_q <= seq_q + 16'd1;
				end else begin
					valid_q[best_idx_q] <= 1'b0;
				end
			end
			if (cmd.flush) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_q <= timer_tag;
			delay_q <= delay;
			period_q <= period;
			limit_q <= fire_limit;
		end
		vidx_s1 <= idx_q;
		if (vld_s1 && sel_q && take) begin
			best_idx_q <= vidx_s1;
			best_q <= rd_word;
		end
		if (cmd.add) begin
			result_kind <= free_any ? rtq_pkg::KIND_ADDED : rtq_pkg::KIND_FULL;
			tag_out <= tag_q;
			slot_index <= free_any ? 4'(XW'(free_idx)) : 4'd0;
			fire_time <= time_q;
			last <= 1'b1;
		end
		if (cmd.fire) begin
			pend_tag_q <= best_q.tag;
			pend_idx_q <= best_idx_q;
			pend_time_q <= time_q;
		end
		if (cmd.fire || cmd.flush) begin
			result_kind <= rtq_pkg::KIND_FIRED;
			tag_out <= pend_tag_q;
			slot_index <= 4'(XW'(pend_idx_q));
			fire_time <= pend_time_q;
			last <= cmd.flush;
		end
	end

endmodule
`default_nettype wire

/* src/repeating_timer_queue.sv */
// A table of timers driven by add requests and one-second ticks.
// An item is taken when start is high and busy is low; req_type picks an
// add (store a timer in the lowest free slot) or a tick (advance time by
// one and fire every due timer in expiry order, older entries first).
// Each result appears for one cycle with strobe high; last marks the final
// result of an item. The receiver cannot stall, so results are never held.
// An add raises busy only for its add state; its result is registered there
// and shows in the cycle after, as busy falls.
// A tick scans the slot memory once to mark due timers, then once more for
// each timer it fires, and busy stays high through all of these scans; the
// single read port of the slot memory makes the scans run one after another.
// Each fired result is held back one selection, so it is shown when the
// next timer is chosen or when the tick ends, as busy falls.
// At most sixteen timers fire per tick; the rest fire on later ticks.
// Reset clears the time, the insert sequence and all slot valid bits; the
// slot memory itself needs no clearing.
`default_nettype none
module repeating_timer_queue #(
	parameter int TIMER_SLOTS = rtq_pkg::DefaultSlots
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic req_type,
	input wire logic [7:0] timer_tag,
	input wire logic [19:0] delay,
	input wire logic [19:0] period,
	input wire logic [15:0] fire_limit,
	output logic strobe,
	output logic [1:0] result_kind,
	output logic [7:0] tag_out,
	output logic [3:0] slot_index,
	output logic [31:0] fire_time,
	output logic last
);

	rtq_pkg::rtq_cmd_t cmd;
	rtq_pkg::rtq_status_t status;

	rtq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req_type(req_type),
		.status(status),
		.cmd(cmd),
		.busy(busy)
	);

	rtq_dp #(.TIMER_SLOTS(TIMER_SLOTS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.timer_tag(timer_tag),
		.delay(delay),
		.period(period),
		.fire_limit(fire_limit),
		.req_type(req_type),
		.strobe(strobe),
		.result_kind(result_kind),
		.tag_out(tag_out),
		.slot_index(slot_index),
		.fire_time(fire_time),
		.last(last)
	);

	a_add_answers: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == rtq_pkg::REQ_ADD) |-> ##2 strobe && last)
		else $error("add item did not answer in two cycles");

	a_add_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result_kind != rtq_pkg::KIND_FIRED) |-> last)
		else $error("add result without last");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result_kind == rtq_pkg::KIND_ADDED) || (result_kind == rtq_pkg::KIND_FULL)
			|| (result_kind == rtq_pkg::KIND_FIRED))
		else $error("illegal result kind");

endmodule
`default_nettype wire

/* bench/tb_repeating_timer_queue.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_repeating_timer_queue;

	localparam int Slots = 16;

	typedef struct packed {
		logic kind;
		logic [7:0] tag;
		logic [19:0] delay;
		logic [19:0] period;
		logic [15:0] limit;
	} timer_req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] tag;
		logic [3:0] slot;
		logic [31:0] at;
		logic last;
	} timer_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic req_type = 1'b0;
	logic [7:0] timer_tag = '0;
	logic [19:0] delay = '0;
	logic [19:0] period = '0;
	logic [15:0] fire_limit = '0;
	logic strobe;
	logic [1:0] result_kind;
	logic [7:0] tag_out;
	logic [3:0] slot_index;
	logic [31:0] fire_time;
	logic last;

	repeating_timer_queue uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .timer_tag(timer_tag), .delay(delay),
		.period(period), .fire_limit(fire_limit), .strobe(strobe),
		.result_kind(result_kind), .tag_out(tag_out), .slot_index(slot_index),
		.fire_time(fire_time), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	timer_req_t pending_reqs[$];
	timer_event_t expected_events[$];
	int mismatches = 0;
	int accepted = 0;
	int burst_left = 0;
	int gap_left = 0;

	logic [31:0] now_sec;
	logic [15:0] seq_no;
	logic used[Slots];
	logic [31:0] exp_at[Slots];
	logic [19:0] per[Slots];
	logic [15:0] lim[Slots];
	logic [15:0] fired_cnt[Slots];
	logic [7:0] tag_of[Slots];
	logic [15:0] age_stamp[Slots];

	function automatic void queue_req(timer_req_t r);
		pending_reqs = {pending_reqs, r};
	endfunction

	function automatic void note_event(timer_event_t ev);
		expected_events = {expected_events, ev};
	endfunction

	function automatic logic fires_first(int a, int b);
		logic [15:0] age_a, age_b;
		age_a = seq_no - age_stamp[a];
		age_b = seq_no - age_stamp[b];
		if (exp_at[a] != exp_at[b])
			return exp_at[a] < exp_at[b];
		if (age_a != age_b)
			return age_a > age_b;
		return a < b;
	endfunction

	task automatic predict_timers(input timer_req_t r);
		timer_event_t ev;
		logic due[Slots];
		int n, best, s;
		n = 0;
		if (r.kind == rtq_pkg::REQ_ADD) begin
			ev = '{rtq_pkg::KIND_FULL, r.tag, 4'd0, now_sec, 1'b1};
			for (s = 0; s < Slots; s++) begin
				if (!used[s]) begin
					used[s] = 1'b1;
					exp_at[s] = now_sec + r.delay;
					per[s] = r.period;
					lim[s] = r.limit;
					fired_cnt[s] = '0;
					tag_of[s] = r.tag;
					age_stamp[s] = seq_no;
					seq_no++;
					ev.kind = rtq_pkg::KIND_ADDED;
					ev.slot = s[3:0];
					break;
				end
			end
			note_event(ev);
			return;
		end
		now_sec++;
		for (s = 0; s < Slots; s++)
			due[s] = used[s] && exp_at[s] < now_sec;
		while (n < rtq_pkg::MaxResults) begin
			best = -1;
			for (s = 0; s < Slots; s++)
				if (due[s] && (best < 0 || fires_first(s, best)))
					best = s;
			if (best < 0)
				break;
			due[best] = 1'b0;
			if (fired_cnt[best] != 16'hFFFF)
				fired_cnt[best]++;
			if (n > 0)
				expected_events[$].last = 1'b0;
			note_event('{rtq_pkg::KIND_FIRED, tag_of[best], best[3:0], now_sec, 1'b1});
			n++;
			if (per[best] != 0 && (lim[best] == 0 || fired_cnt[best] < lim[best])) begin
				exp_at[best] = now_sec + per[best];
				age_stamp[best] = seq_no;
				seq_no++;
			end else begin
				used[best] = 1'b0;
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (start) begin
				start <= 1'b0;
			end else if (!busy) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() > 0) begin
					timer_req_t r;
					r = pending_reqs.pop_front();
					start <= 1'b1;
					req_type <= r.kind;
					timer_tag <= r.tag;
					delay <= r.delay;
					period <= r.period;
					fire_limit <= r.limit;
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 12);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_timers('{req_type, timer_tag, delay, period, fire_limit});
				accepted++;
			end
			if (strobe) begin
				timer_event_t got, want;
				got = '{result_kind, tag_out, slot_index, fire_time, last};
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: %p", got);
				end else begin
					want = expected_events.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %p, actual %p", want, got);
					end
				end
			end
		end
	end

	function automatic timer_req_t add_req(logic [7:0] t, logic [19:0] d,
		logic [19:0] p, logic [15:0] l);
		return '{rtq_pkg::REQ_ADD, t, d, p, l};
	endfunction

	function automatic timer_req_t tick_req();
		timer_req_t r;
		r.kind = rtq_pkg::REQ_TICK;
		r.tag = 8'($urandom);
		r.delay = 20'($urandom);
		r.period = 20'($urandom);
		r.limit = 16'($urandom);
		return r;
	endfunction

	function automatic logic [19:0] rand_len();
		case ($urandom_range(0, 9))
			0: return 20'(20'hFFFFF - $urandom_range(0, 3));
			1: return 20'($urandom);
			2, 3: return 20'd0;
			default: return 20'($urandom_range(1, 6));
		endcase
	endfunction

	initial begin
		int total;
		for (int s = 0; s < Slots; s++)
			used[s] = 1'b0;
		now_sec = '0;
		seq_no = '0;
		queue_req(tick_req());
		queue_req(add_req(8'h00, 20'd0, 20'd0, 16'd0));
		queue_req(add_req(8'hFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF));
		queue_req(add_req(8'h5A, 20'd0, 20'd1, 16'd3));
		queue_req(add_req(8'hA5, 20'd0, 20'd1, 16'd0));
		queue_req(add_req(8'h11, 20'd1, 20'd0, 16'd7));
		for (int i = 0; i < 12; i++)
			queue_req(add_req(8'h20 + i[7:0], 20'd2, 20'd2, 16'd2));
		for (int i = 0; i < 6; i++)
			queue_req(tick_req());
		total = pending_reqs.size();
		while (total < 200) begin
			if ($urandom_range(0, 2) == 0) begin
				queue_req(tick_req());
			end else begin
				queue_req(add_req(8'($urandom), rand_len(),
					($urandom_range(0, 3) == 0) ? 20'd0 : rand_len(),
					($urandom_range(0, 3) == 0) ? 16'(~$urandom_range(0, 1))
						: 16'($urandom_range(0, 4))));
			end
			total++;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		wait (accepted == total);
		while (expected_events.size() > 0 || busy)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_events.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
